>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// cond must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hdl/spsa_pkg.sv
// ----------------------------------------------------------------------------
// Slotted page allocator package
// Payload types, status codes, controller states and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spsa_pkg;

   localparam int DEF_SLOTS            = 16;
   localparam int DEF_PAGE_BYTES       = 4096;
   localparam int DEF_SLOT_ENTRY_BYTES = 16;

   localparam int LEN_W      = 13;
   localparam int SLOT_NUM_W = 4;
   localparam int STATUS_W   = 2;
   localparam int CHOSEN_W   = 4;
   localparam int ROFF_W     = 12;

   localparam logic [STATUS_W-1:0] ST_DONE         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY_DELETE = 2'd3;

   localparam logic ACT_ADD    = 1'b0;
   localparam logic ACT_DELETE = 1'b1;

   typedef struct packed {
      logic                  action;
      logic [LEN_W-1:0]      record_length;
      logic [SLOT_NUM_W-1:0] slot_number;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CHOSEN_W-1:0] chosen_slot;
      logic [ROFF_W-1:0]   record_offset;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

>>> hdl/slotted_page_space_allocator_top.sv
// ----------------------------------------------------------------------------
// Slotted page space allocator
// Slot directory of one page: add places a record, delete frees a slot.
// ----------------------------------------------------------------------------
// Each request launches a scan wave into a chain of SLOTS cells, one cell per
// cycle, then the result is formed and any placement is written back. A
// new request is accepted only after the wave has left the last cell and the
// result has been loaded, so requests never overlap in the chain; a
// result still waiting on rsp_ready stalls the next write-back, and with it
// the next request transfer, but not the scan.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slotted_page_space_allocator_top
   import spsa_pkg::*;
#(
   parameter int SLOTS            = DEF_SLOTS,
   parameter int PAGE_BYTES       = DEF_PAGE_BYTES,
   parameter int SLOT_ENTRY_BYTES = DEF_SLOT_ENTRY_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int OFF_W     = $clog2(PAGE_BYTES);
   localparam int DIR_BYTES = SLOTS * SLOT_ENTRY_BYTES;
   localparam int PL_MAX    = (DIR_BYTES > PAGE_BYTES) ? DIR_BYTES : PAGE_BYTES;
   localparam int PL_W      = $clog2(PL_MAX + 1);
   localparam int CMP_W     = ((PL_W > LEN_W) ? PL_W : LEN_W) + 1;
   localparam int WAVE_W    = 4 + SLOT_NUM_W + SLOT_W + PL_W;
   localparam int COMMIT_W  = 1 + SLOT_W + OFF_W + LEN_W;

   typedef struct packed {
      logic                  valid;
      logic                  del;
      logic [SLOT_NUM_W-1:0] slot;
      logic                  found;
      logic [SLOT_W-1:0]     free_idx;
      logic [PL_W-1:0]       max_end;
      logic                  hit;
   } wave_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] idx;
      logic [OFF_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
   } commit_type;

   state_type state_ff;
   state_type state_in;

   logic [WAVE_W-1:0] chain [SLOTS+1];

   wave_type         inject_ff;
   wave_type         inject_in;
   wave_type         last_wave;
   wave_type         fin_ff;
   logic [LEN_W-1:0] len_ff;
   commit_type       wr;

   logic    req_fire;
   logic    fin_load;
   logic    rsp_load;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_next;
   logic    add_ok;

   logic [CMP_W-1:0] place_c;
   logic [CMP_W-1:0] room_c;

   assign req_fire  = req_valid && req_ready;
   assign last_wave = wave_type'(chain[SLOTS]);
   assign chain[0]  = inject_ff;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      spsa_cell #(
         .SLOT_W     (SLOT_W),
         .OFF_W      (OFF_W),
         .PL_W       (PL_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_wave (chain[i]),
         .next_wave (chain[i+1]),
         .commit    (COMMIT_W'(wr))
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (last_wave.valid) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      fin_load  = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   fin_load  = last_wave.valid;
         ST_FINISH: rsp_load  = !rsp_valid_ff || rsp_ready;
         default:   req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      inject_in          = '0;
      inject_in.valid    = req_fire;
      inject_in.del      = req_data.action == ACT_DELETE;
      inject_in.slot     = req_data.slot_number;
      inject_in.max_end  = PL_W'(DIR_BYTES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inject_ff <= '0;
      end else begin
         inject_ff <= inject_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         len_ff <= req_data.record_length;
      end
      if (fin_load) begin
         fin_ff <= last_wave;
      end
   end

   assign place_c = CMP_W'(fin_ff.max_end);
   assign room_c  = CMP_W'(PAGE_BYTES) - place_c;

   always_comb begin
      rsp_next = '0;
      add_ok   = 1'b0;
      if (fin_ff.del) begin
         rsp_next.status      = fin_ff.hit ? ST_DONE : ST_EMPTY_DELETE;
         rsp_next.chosen_slot = fin_ff.slot;
      end else if (!fin_ff.found) begin
         rsp_next.status = ST_NO_SLOT;
      end else if ((place_c >= CMP_W'(PAGE_BYTES)) || (CMP_W'(len_ff) > room_c)) begin
         rsp_next.status = ST_NO_SPACE;
      end else begin
         add_ok                 = 1'b1;
         rsp_next.status        = ST_DONE;
         rsp_next.chosen_slot   = CHOSEN_W'(fin_ff.free_idx);
         rsp_next.record_offset = ROFF_W'(fin_ff.max_end);
      end
   end

   always_comb begin
      wr.en     = rsp_load && add_ok;
      wr.idx    = fin_ff.free_idx;
      wr.offset = OFF_W'(fin_ff.max_end);
      wr.length = len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_NEVER(a_wave_scan, clock, reset, last_wave.valid && state_ff != ST_SCAN, "late wave")
   `ASSERT_NEVER(a_launch, clock, reset, inject_ff.valid && state_ff != ST_SCAN, "stray launch")
   `ASSERT_HOLDS(a_rsp_seq, clock, reset, $rose(rsp_valid) |-> $past(rsp_load), "stray result")

endmodule

>>> hdl/spsa_cell.sv
// ----------------------------------------------------------------------------
// Slot cell
// Holds one directory entry and folds it into the scan wave passing by.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spsa_cell
   import spsa_pkg::*;
#(
   parameter int SLOT_W     = 4,
   parameter int OFF_W      = 12,
   parameter int PL_W       = 13,
   parameter int CELL_INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [3+SLOT_NUM_W+SLOT_W+PL_W:0] prev_wave,
   output logic [3+SLOT_NUM_W+SLOT_W+PL_W:0] next_wave,
   input  logic [SLOT_W+OFF_W+LEN_W:0]   commit
);

   typedef struct packed {
      logic                  valid;
      logic                  del;
      logic [SLOT_NUM_W-1:0] slot;
      logic                  found;
      logic [SLOT_W-1:0]     free_idx;
      logic [PL_W-1:0]       max_end;
      logic                  hit;
   } wave_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] idx;
      logic [OFF_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
   } commit_type;

   localparam int SEL_W = (SLOT_NUM_W > SLOT_W) ? SLOT_NUM_W : SLOT_W;

   wave_type   wave_prev;
   wave_type   wave_ff;
   wave_type   wave_in;
   commit_type wr;

   logic             used_ff;
   logic             used_in;
   logic [OFF_W-1:0] offset_ff;
   logic [LEN_W-1:0] length_ff;
   logic [PL_W-1:0]  end_pos;
   logic             del_match;
   logic             wr_match;

   assign wave_prev = wave_type'(prev_wave);
   assign wr        = commit_type'(commit);
   assign next_wave = wave_ff;

   assign end_pos   = PL_W'(offset_ff) + PL_W'(length_ff);
   assign del_match = SEL_W'(wave_prev.slot) == SEL_W'(CELL_INDEX);
   assign wr_match  = wr.en && (wr.idx == SLOT_W'(CELL_INDEX));

   always_comb begin
      wave_in = wave_prev;
      used_in = used_ff;
      if (wave_prev.valid) begin
         if (wave_prev.del) begin
            if (del_match && used_ff) begin
               wave_in.hit = 1'b1;
               used_in     = 1'b0;
            end
         end else begin
            if (!used_ff && !wave_prev.found) begin
               wave_in.found    = 1'b1;
               wave_in.free_idx = SLOT_W'(CELL_INDEX);
            end
            if (used_ff && (end_pos > wave_prev.max_end)) begin
               wave_in.max_end = end_pos;
            end
         end
      end
      if (wr_match) begin
         used_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= '0;
      end else begin
         wave_ff <= wave_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_match) begin
         offset_ff <= wr.offset;
         length_ff <= wr.length;
      end
   end

   `ASSERT_NEVER(a_commit_free, clock, reset, wr_match && used_ff, "commit to occupied slot")
   `ASSERT_NEVER(a_wave_commit, clock, reset, wr_match && wave_prev.valid, "commit during scan")
   `ASSERT_NEVER(a_hit_add, clock, reset, wave_ff.hit && !wave_ff.del, "add hit")

endmodule
